// ===== design/jsu_pkg.sv =====
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int MaxResults = 4;
    localparam int CountW     = $clog2(MaxResults + 1);
    localparam int IdxW       = $clog2(MaxResults);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    localparam logic [7:0] CTRL_BS   = 8'h08;
    localparam logic [7:0] CTRL_FF   = 8'h0C;
    localparam logic [7:0] CTRL_LF   = 8'h0A;
    localparam logic [7:0] CTRL_CR   = 8'h0D;
    localparam logic [7:0] CTRL_TAB  = 8'h09;

    localparam logic [15:0] HI_SURR_MIN = 16'hD800;
    localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    typedef enum logic [1:0] {
        ST_DATA     = 2'd0,
        ST_END      = 2'd1,
        ST_NO_QUOTE = 2'd2
    } status_t;

    typedef struct packed {
        logic [MaxResults-1:0][7:0] data;
        logic [CountW-1:0]          count;
        status_t                    status;
    } result_t;

    function automatic result_t utf8_encode(input logic [20:0] cp);
        result_t r;
        r        = '0;
        r.status = ST_DATA;
        if (cp < 21'h80)
        begin
            r.count   = CountW'(1);
            r.data[0] = cp[7:0];
        end
        else if (cp < 21'h800)
        begin
            r.count   = CountW'(2);
            r.data[0] = {3'b110, cp[10:6]};
            r.data[1] = {2'b10, cp[5:0]};
        end
        else if (cp < 21'h10000)
        begin
            r.count   = CountW'(3);
            r.data[0] = {4'b1110, cp[15:12]};
            r.data[1] = {2'b10, cp[11:6]};
            r.data[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            r.count   = CountW'(4);
            r.data[0] = {5'b11110, cp[20:18]};
            r.data[1] = {2'b10, cp[17:12]};
            r.data[2] = {2'b10, cp[11:6]};
            r.data[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

// ===== design/jsu_decode.sv =====
`timescale 1ns / 1ps

module jsu_decode
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    output result_t    res
);

    typedef enum logic [2:0] {
        M_IDLE = 3'd0,
        M_BODY = 3'd1,
        M_ESC  = 3'd2,
        M_HEX1 = 3'd3,
        M_PBS  = 3'd4,
        M_PU   = 3'd5,
        M_HEX2 = 3'd6
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] acc_reg, acc_next;
    logic        bad_reg, bad_next;
    logic [9:0]  hi_reg, hi_next;

    mode_t       body_mode;
    result_t     body_res;
    mode_t       esc_mode;
    result_t     esc_res;
    logic        esc_hex;

    logic        digit_ok;
    logic [3:0]  digit;
    logic [15:0] acc_sh;
    logic        bad_sh;
    logic [15:0] uc;
    logic [20:0] pair_cp;

    always_comb
    begin
        body_mode = M_BODY;
        body_res  = '0;
        if (in_byte == CH_QUOTE || in_byte == CH_NUL)
        begin
            body_mode      = M_IDLE;
            body_res.count = CountW'(1);
            body_res.status = ST_END;
        end
        else if (in_byte == CH_BSLASH)
        begin
            body_mode = M_ESC;
        end
        else
        begin
            body_res.count   = CountW'(1);
            body_res.data[0] = in_byte;
        end
    end

    always_comb
    begin
        esc_mode = M_BODY;
        esc_res  = '0;
        esc_hex  = 1'b0;
        esc_res.count = CountW'(1);
        unique case (in_byte)
            CH_NUL:
            begin
                esc_mode       = M_IDLE;
                esc_res.status = ST_END;
            end
            CH_LOW_B: esc_res.data[0] = CTRL_BS;
            CH_LOW_F: esc_res.data[0] = CTRL_FF;
            CH_LOW_N: esc_res.data[0] = CTRL_LF;
            CH_LOW_R: esc_res.data[0] = CTRL_CR;
            CH_LOW_T: esc_res.data[0] = CTRL_TAB;
            CH_LOW_U:
            begin
                esc_mode      = M_HEX1;
                esc_hex       = 1'b1;
                esc_res.count = '0;
            end
            default:  esc_res.data[0] = in_byte;
        endcase
    end

    always_comb
    begin
        digit_ok = 1'b1;
        digit    = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
            digit = in_byte[3:0];
        else if ((in_byte >= 8'h41 && in_byte <= 8'h46) ||
                 (in_byte >= 8'h61 && in_byte <= 8'h66))
            digit = in_byte[3:0] + 4'd9;
        else
            digit_ok = 1'b0;
    end

    assign acc_sh  = {acc_reg[11:0], digit};
    assign bad_sh  = bad_reg | ~digit_ok;
    assign uc      = bad_sh ? 16'd0 : acc_sh;
    assign pair_cp = SUPP_BASE + {1'b0, hi_reg, acc_sh[9:0]};

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        bad_next  = bad_reg;
        hi_next   = hi_reg;
        res       = '0;
        unique case (mode_reg)
            M_BODY:
            begin
                mode_next = body_mode;
                res       = body_res;
            end
            M_ESC:
            begin
                mode_next = esc_mode;
                res       = esc_res;
                if (esc_hex)
                begin
                    cnt_next = 2'd0;
                    acc_next = 16'd0;
                    bad_next = 1'b0;
                end
            end
            M_HEX1, M_HEX2:
            begin
                if (in_byte == CH_NUL)
                begin
                    mode_next  = M_IDLE;
                    res.count  = CountW'(1);
                    res.status = ST_END;
                end
                else
                begin
                    acc_next = acc_sh;
                    bad_next = bad_sh;
                    if (cnt_reg == 2'd3)
                    begin
                        cnt_next  = 2'd0;
                        mode_next = M_BODY;
                        if (mode_reg == M_HEX1)
                        begin
                            if (uc >= HI_SURR_MIN && uc <= HI_SURR_MAX)
                            begin
                                hi_next   = uc[9:0];
                                mode_next = M_PBS;
                            end
                            else if (uc != 16'd0 &&
                                     !(uc >= LO_SURR_MIN && uc <= LO_SURR_MAX))
                            begin
                                res = utf8_encode({5'd0, uc});
                            end
                        end
                        else if (!bad_sh && acc_sh >= LO_SURR_MIN && acc_sh <= LO_SURR_MAX)
                        begin
                            res = utf8_encode(pair_cp);
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
            end
            M_PBS:
            begin
                if (in_byte == CH_BSLASH)
                begin
                    mode_next = M_PU;
                end
                else
                begin
                    mode_next = body_mode;
                    res       = body_res;
                end
            end
            M_PU:
            begin
                if (in_byte == CH_LOW_U)
                begin
                    mode_next = M_HEX2;
                    cnt_next  = 2'd0;
                    acc_next  = 16'd0;
                    bad_next  = 1'b0;
                end
                else
                begin
                    mode_next = esc_mode;
                    res       = esc_res;
                    if (esc_hex)
                    begin
                        cnt_next = 2'd0;
                        acc_next = 16'd0;
                        bad_next = 1'b0;
                    end
                end
            end
            default:
            begin
                if (in_byte == CH_QUOTE)
                begin
                    mode_next = M_BODY;
                end
                else
                begin
                    mode_next  = M_IDLE;
                    res.count  = CountW'(1);
                    res.status = ST_NO_QUOTE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            cnt_reg  <= 2'd0;
            acc_reg  <= 16'd0;
            bad_reg  <= 1'b0;
            hi_reg   <= 10'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
            bad_reg  <= bad_next;
            hi_reg   <= hi_next;
        end
    end

endmodule

// ===== design/jsu_emit.sv =====
`timescale 1ns / 1ps

module jsu_emit
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  result_t    res,
    output logic       ready,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [1:0] status,
    output logic       last_of_run
);

    logic [MaxResults-1:0][7:0] data_reg;
    logic [CountW-1:0]          count_reg;
    logic [IdxW-1:0]            idx_reg;
    status_t                    status_reg;
    logic                       valid_reg;
    logic                       take;

    assign out_valid   = valid_reg;
    assign out_byte    = data_reg[idx_reg];
    assign status      = status_reg;
    assign last_of_run = (CountW'(idx_reg) + CountW'(1)) == count_reg;
    assign take        = valid_reg & ~out_stall;
    assign ready       = ~valid_reg | (take & last_of_run);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (take)
        begin
            if (last_of_run)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + IdxW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg   <= res.data;
            count_reg  <= res.count;
            status_reg <= res.status;
        end
    end

endmodule

// ===== design/json_string_unescape_utf8.sv =====
// Results of an item appear in the cycle after the item is accepted.
// Throughput: one item per cycle while each item yields at most one result and the output does not stall;
// an item that yields more than one result (up to four UTF-8 bytes) holds input while the
// single result register drains them, one byte per cycle unless the output stalls.
// Reset (rst_n, async, active low): decoder returns to waiting for the opening quote.
`timescale 1ns / 1ps

module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [1:0] status,
    output logic       last_of_run
);

    logic    accept;
    logic    ready;
    logic    load;
    result_t res;

    assign in_stall = ~ready;
    assign accept   = in_valid & ready;
    assign load     = accept & (res.count != '0);

    jsu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .res     (res)
    );

    jsu_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .res         (res),
        .ready       (ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .status      (status),
        .last_of_run (last_of_run)
    );

    a_single_non_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DATA |-> last_of_run && out_byte == 8'd0)
        else $error("non-data result not a single zero-byte result");

    a_stall_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no pending result");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid && status == ST_DATA)
        else $error("multi-byte run broken");

    a_load_counts: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> res.count <= CountW'(MaxResults))
        else $error("result count out of range");

endmodule

// ===== dv/unescape_checker.sv =====
`timescale 1ns / 1ps

module unescape_checker
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte,
    input  logic [1:0] status,
    input  logic       last_of_run,
    output int         errors,
    output int         pending
);

    typedef enum logic [2:0] {
        DM_IDLE        = 3'd0,
        DM_BODY        = 3'd1,
        DM_ESCAPE      = 3'd2,
        DM_HEX_FIRST   = 3'd3,
        DM_WANT_BSLASH = 3'd4,
        DM_WANT_U      = 3'd5,
        DM_HEX_SECOND  = 3'd6
    } decode_mode_t;

    typedef struct packed {
        logic [7:0] data;
        status_t    st;
        logic       last;
    } decoded_t;

    decode_mode_t mode      = DM_IDLE;
    logic [1:0]   digit_cnt = '0;
    logic [15:0]  code_acc  = '0;
    logic         bad_digit = 1'b0;
    logic [9:0]   high_bits = '0;
    decoded_t     decoded_q[$];

    function automatic void emit(input logic [7:0] b, input status_t st);
        decoded_t r;
        r.data = b;
        r.st   = st;
        r.last = 1'b0;
        decoded_q.push_back(r);
    endfunction

    function automatic void emit_code_point(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            emit(cp[7:0], ST_DATA);
        end
        else if (cp < 21'h800)
        begin
            emit(8'hC0 | 8'(cp[10:6]), ST_DATA);
            emit(8'h80 | 8'(cp[5:0]), ST_DATA);
        end
        else if (cp < 21'h10000)
        begin
            emit(8'hE0 | 8'(cp[15:12]), ST_DATA);
            emit(8'h80 | 8'(cp[11:6]), ST_DATA);
            emit(8'h80 | 8'(cp[5:0]), ST_DATA);
        end
        else
        begin
            emit(8'hF0 | 8'(cp[20:18]), ST_DATA);
            emit(8'h80 | 8'(cp[17:12]), ST_DATA);
            emit(8'h80 | 8'(cp[11:6]), ST_DATA);
            emit(8'h80 | 8'(cp[5:0]), ST_DATA);
        end
    endfunction

    function automatic void end_string();
        mode = DM_IDLE;
        emit(8'h00, ST_END);
    endfunction

    function automatic void start_hex();
        digit_cnt = '0;
        code_acc  = '0;
        bad_digit = 1'b0;
    endfunction

    function automatic void body_byte(input logic [7:0] b);
        mode = DM_BODY;
        if (b == CH_QUOTE || b == CH_NUL)
            end_string();
        else if (b == CH_BSLASH)
            mode = DM_ESCAPE;
        else
            emit(b, ST_DATA);
    endfunction

    function automatic void escape_byte(input logic [7:0] b);
        mode = DM_BODY;
        case (b)
            CH_NUL:   end_string();
            CH_LOW_B: emit(CTRL_BS, ST_DATA);
            CH_LOW_F: emit(CTRL_FF, ST_DATA);
            CH_LOW_N: emit(CTRL_LF, ST_DATA);
            CH_LOW_R: emit(CTRL_CR, ST_DATA);
            CH_LOW_T: emit(CTRL_TAB, ST_DATA);
            CH_LOW_U:
            begin
                mode = DM_HEX_FIRST;
                start_hex();
            end
            default:  emit(b, ST_DATA);
        endcase
    endfunction

    function automatic logic take_hex_digit(input logic [7:0] b);
        logic [3:0] nib;
        logic       done;
        nib = 4'h0;
        if (b >= 8'h30 && b <= 8'h39)
            nib = 4'(b - 8'h30);
        else if (b >= 8'h41 && b <= 8'h46)
            nib = 4'(b - 8'h37);
        else if (b >= 8'h61 && b <= 8'h66)
            nib = 4'(b - 8'h57);
        else
            bad_digit = 1'b1;
        code_acc  = {code_acc[11:0], nib};
        done      = (digit_cnt == 2'd3);
        digit_cnt = digit_cnt + 2'd1;
        return done;
    endfunction

    function automatic void finish_first();
        logic [15:0] uc;
        uc   = bad_digit ? 16'h0000 : code_acc;
        mode = DM_BODY;
        if (uc == 16'h0000 || (uc >= LO_SURR_MIN && uc <= LO_SURR_MAX))
            return;
        if (uc >= HI_SURR_MIN && uc <= HI_SURR_MAX)
        begin
            high_bits = uc[9:0];
            mode      = DM_WANT_BSLASH;
            return;
        end
        emit_code_point(21'(uc));
    endfunction

    function automatic void finish_second();
        mode = DM_BODY;
        if (bad_digit || code_acc < LO_SURR_MIN || code_acc > LO_SURR_MAX)
            return;
        emit_code_point(SUPP_BASE + 21'({high_bits, code_acc[9:0]}));
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        int       prev_size;
        decoded_t tail;
        prev_size = decoded_q.size();
        case (mode)
            DM_BODY:   body_byte(b);
            DM_ESCAPE: escape_byte(b);
            DM_HEX_FIRST, DM_HEX_SECOND:
            begin
                if (b == CH_NUL)
                    end_string();
                else if (take_hex_digit(b))
                begin
                    if (mode == DM_HEX_FIRST)
                        finish_first();
                    else
                        finish_second();
                end
            end
            DM_WANT_BSLASH:
            begin
                if (b == CH_BSLASH)
                    mode = DM_WANT_U;
                else
                    body_byte(b);
            end
            DM_WANT_U:
            begin
                if (b == CH_LOW_U)
                begin
                    mode = DM_HEX_SECOND;
                    start_hex();
                end
                else
                begin
                    escape_byte(b);
                end
            end
            default:
            begin
                if (b == CH_QUOTE)
                begin
                    mode = DM_BODY;
                end
                else
                begin
                    mode = DM_IDLE;
                    emit(8'h00, ST_NO_QUOTE);
                end
            end
        endcase
        if (decoded_q.size() > prev_size)
        begin
            tail      = decoded_q.pop_back();
            tail.last = 1'b1;
            decoded_q.push_back(tail);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        decoded_t want;
        if (!rst_n)
        begin
            mode      = DM_IDLE;
            digit_cnt = '0;
            code_acc  = '0;
            bad_digit = 1'b0;
            high_bits = '0;
            decoded_q.delete();
            pending   = 0;
            errors    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected result: out_byte %02h status %0d last_of_run %0b",
                           out_byte, status, last_of_run);
                    errors++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.data, out_byte);
                        errors++;
                    end
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, status);
                        errors++;
                    end
                    if (last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                decode_byte(in_byte);
            pending = decoded_q.size();
        end
    end

endmodule

// ===== dv/json_string_unescape_utf8_tb.sv =====
`timescale 1ns / 1ps

module json_string_unescape_utf8_tb;
    import jsu_pkg::*;

    localparam int NumItems      = 450;
    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 8;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last_of_run;

    int   errors;
    int   pending;
    int   sent        = 0;
    int   gap_pct     = 0;
    int   stall_pct   = 0;
    int   idle_cycles = 0;
    logic in_took     = 1'b0;

    json_string_unescape_utf8 i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .status      (status),
        .last_of_run (last_of_run)
    );

    unescape_checker i_unescape_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .status      (status),
        .last_of_run (last_of_run),
        .errors      (errors),
        .pending     (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        in_took <= in_valid && !in_stall;

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall))
            idle_cycles = idle_cycles + 1;
        else
            idle_cycles = 0;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // hold the item until taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(negedge clk);
        while (!in_took);
        sent++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return 8'h30 + 8'(nib);
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    function automatic logic [7:0] esc_char();
        logic [7:0] c;
        case ($urandom_range(8))
            0: c = CH_LOW_B;
            1: c = CH_LOW_F;
            2: c = CH_LOW_N;
            3: c = CH_LOW_R;
            4: c = CH_LOW_T;
            5: c = CH_QUOTE;
            6: c = CH_BSLASH;
            7: c = 8'h2F;
            default:
            begin
                do
                    c = 8'($urandom_range(1, 255));
                while (c == CH_LOW_U);
            end
        endcase
        return c;
    endfunction

    task automatic send_u(input logic [15:0] word, input logic bad);
        int         bad_pos;
        logic [7:0] c;
        bad_pos = bad ? int'($urandom_range(3)) : -1;
        send_byte(CH_BSLASH);
        send_byte(CH_LOW_U);
        for (int i = 3; i >= 0; i--)
        begin
            if (i == bad_pos)
            begin
                if ($urandom_range(3) == 0)
                begin
                    c = CH_QUOTE;
                end
                else
                begin
                    do
                        c = 8'($urandom_range(1, 255));
                    while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                           (c >= 8'h61 && c <= 8'h66));
                end
            end
            else
            begin
                c = hex_char(word[i*4 +: 4]);
            end
            send_byte(c);
        end
    endtask

    task automatic send_random_string();
        int          kind;
        int          v;
        logic [15:0] word;
        if ($urandom_range(9) == 0)
        begin
            send_byte(8'($urandom_range(255)));
            return;
        end
        send_byte(CH_QUOTE);
        repeat ($urandom_range(1, 6))
        begin
            kind = $urandom_range(99);
            if (kind < 35)
            begin
                send_byte(plain_char());
            end
            else if (kind < 55)
            begin
                send_byte(CH_BSLASH);
                send_byte(esc_char());
            end
            else if (kind < 80)
            begin
                case ($urandom_range(5))
                    0: word = 16'($urandom_range(1, 'h7F));
                    1: word = 16'($urandom_range('h80, 'h7FF));
                    2: word = $urandom_range(1) ? 16'($urandom_range('h800, 'hD7FF))
                                                : 16'($urandom_range('hE000, 'hFFFF));
                    3: word = 16'h0000;
                    4: word = LO_SURR_MIN | 16'($urandom_range('h3FF));
                    default: word = 16'($urandom_range('hFFFF));
                endcase
                send_u(word, $urandom_range(7) == 0);
            end
            else
            begin
                send_u(HI_SURR_MIN | 16'($urandom_range('h3FF)), 1'b0);
                v = $urandom_range(9);
                if (v < 6)
                begin
                    send_u(LO_SURR_MIN | 16'($urandom_range('h3FF)), v == 5);
                end
                else if (v == 6)
                begin
                    word = $urandom_range(1) ? 16'($urandom_range('hDBFF))
                                             : 16'($urandom_range('hE000, 'hFFFF));
                    send_u(word, 1'b0);
                end
                else if (v == 7)
                begin
                    if ($urandom_range(1))
                        send_byte(plain_char());
                end
                else
                begin
                    send_byte(CH_BSLASH);
                    send_byte(esc_char());
                end
            end
        end
        v = $urandom_range(9);
        if (v < 7)
        begin
            send_byte(CH_QUOTE);
        end
        else if (v == 7)
        begin
            send_byte(CH_NUL);
        end
        else if (v == 8)
        begin
            send_byte(CH_BSLASH);
            send_byte(CH_NUL);
        end
        else
        begin
            send_byte(CH_BSLASH);
            send_byte(CH_LOW_U);
            repeat ($urandom_range(3))
                send_byte(hex_char(4'($urandom_range(15))));
            send_byte(CH_NUL);
        end
    endtask

    initial
    begin
        int base;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_byte   = 8'h00;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_byte(8'h78);
        send_byte(CH_QUOTE);
        send_byte(8'h41);
        send_byte(8'hFF);
        send_byte(CH_BSLASH);
        send_byte(CH_LOW_N);
        send_byte(CH_BSLASH);
        send_byte(8'h71);
        send_u(16'h00E9, 1'b0);
        send_u(16'hDBFF, 1'b0);
        send_u(16'hDFFF, 1'b0);
        send_byte(CH_QUOTE);
        send_byte(CH_QUOTE);
        send_byte(CH_NUL);

        base = sent;
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 78;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 78;
                end
                default:
                begin
                    gap_pct   = 19;
                    stall_pct = 19;
                end
            endcase
            while (sent < base + (p + 1) * NumItems / 4)
                send_random_string();
        end
        in_valid <= 1'b0;
        stall_pct = 0;

        while (pending != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
